FILE: hdl/ipid_pkg.sv
// Package for the incremental PID controller: payload words, configuration
// layout, register indexes and the command/status structs of the shared unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

    localparam int FRAC_BITS_DEF = 16;   // Q16.16 by default
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int COEF_W        = 31;   // gain and time constants
    localparam int MUL_STEPS     = 32;   // multiplier operand bits
    localparam int OPND_W        = 64;   // multiplicand / dividend width
    localparam int ACC_W         = 96;   // full product width
    localparam int TERM_W        = 61;   // saturated term, up to 2^60

    localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [31:0]       INT_MAX  = 32'h7fff_ffff;
    localparam logic [31:0]       INT_MIN  = 32'h8000_0000;

    localparam logic [COEF_W-1:0] GAIN_RST   = 31'd6554;
    localparam logic [COEF_W-1:0] TINT_RST   = 31'd655360;
    localparam logic [COEF_W-1:0] TDER_RST   = 31'd2621440;
    localparam logic [COEF_W-1:0] TSTEP_RST  = 31'd655360;
    localparam logic [31:0]       TARGET_RST = 32'd327680;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN            = 3'd0,
        REG_INTEGRAL_TIME   = 3'd1,
        REG_DERIVATIVE_TIME = 3'd2,
        REG_SAMPLE_STEP     = 3'd3,
        REG_TARGET_VALUE    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] measured;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] error_now;
        logic signed [31:0] drive;
        logic               clipped;
    } t_out_word;

    typedef struct packed {
        logic [COEF_W-1:0]  gain;
        logic [COEF_W-1:0]  integral_time;
        logic [COEF_W-1:0]  derivative_time;
        logic [COEF_W-1:0]  sample_step;
        logic signed [31:0] target_value;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        t_alu_op              op;
        logic [OPND_W-1:0]    opnd_a;   // multiplicand or dividend
        logic [MUL_STEPS-1:0] opnd_b;   // multiplier or divisor
    } t_alu_cmd;

    typedef struct packed {
        logic              done;
        logic [OPND_W-1:0] quo;
        logic [TERM_W-1:0] prod;        // min(product >> frac bits, 2^60)
    } t_alu_sts;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_push;

endpackage

`default_nettype wire

FILE: hdl/ipid_alu.sv
// Shared iterative unit: shift-add multiplier and restoring divider on one
// wide adder, one bit per cycle. Depends on ipid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipid_alu #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ipid_pkg::t_alu_cmd i_cmd,
    output ipid_pkg::t_alu_sts      o_sts
);
    import ipid_pkg::*;

    localparam int QUO_W    = COEF_W + FRAC_BITS;
    localparam int STEP_MAX = (QUO_W > MUL_STEPS) ? QUO_W : MUL_STEPS;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    t_alu_op              r_op, n_op;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [ACC_W-1:0]     r_mcand, n_mcand;
    logic [MUL_STEPS-1:0] r_mplier, n_mplier;

    logic [31:0]          w_rem_sh;
    logic [ACC_W:0]       w_add_a, w_add_b, w_sum;
    logic                 w_cin;
    logic                 w_qbit;
    logic [ACC_W-1:0]     w_prod_sh;

    // In divide mode the accumulator holds the remainder and the multiplicand
    // register shifts the dividend out at the top and the quotient in below.
    always_comb begin
        w_rem_sh = {r_acc[30:0], r_mcand[QUO_W-1]};
        if (r_op == ALU_DIV) begin
            w_add_a = (ACC_W+1)'(w_rem_sh);
            w_add_b = ~((ACC_W+1)'(r_mplier));
            w_cin   = 1'b1;
        end else begin
            w_add_a = {1'b0, r_acc};
            w_add_b = r_mplier[0] ? {1'b0, r_mcand} : '0;
            w_cin   = 1'b0;
        end
        w_sum  = w_add_a + w_add_b + (ACC_W+1)'(w_cin);
        w_qbit = ~w_sum[ACC_W];
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_op     = r_op;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_cmd.start) begin
            n_op     = i_cmd.op;
            n_cnt    = (i_cmd.op == ALU_DIV) ? CNT_W'(QUO_W) : CNT_W'(MUL_STEPS);
            n_acc    = '0;
            n_mcand  = ACC_W'(i_cmd.opnd_a);
            n_mplier = i_cmd.opnd_b;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
            if (r_op == ALU_DIV) begin
                n_acc   = w_qbit ? ACC_W'(w_sum[31:0]) : ACC_W'(w_rem_sh);
                n_mcand = {r_mcand[ACC_W-2:0], w_qbit};
            end else begin
                n_acc    = w_sum[ACC_W-1:0];
                n_mcand  = {r_mcand[ACC_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[MUL_STEPS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    // Anything at or above 2^60 after the fraction shift reads as the limit.
    assign w_prod_sh  = r_acc >> FRAC_BITS;
    assign o_sts.done = r_done;
    assign o_sts.quo  = OPND_W'(r_mcand[QUO_W-1:0]);
    assign o_sts.prod = (|w_prod_sh[ACC_W-1:TERM_W-1]) ? TERM_LIM
                                                       : w_prod_sh[TERM_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/ipid_ctrl.sv
// Sequencer of the PID step: error forming, coefficient and term schedule on
// the shared unit, accumulation, saturation and error history. Depends on
// ipid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipid_ctrl #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ipid_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ipid_pkg::t_in_word i_in_word,
    output ipid_pkg::t_alu_cmd      o_alu_cmd,
    input  wire ipid_pkg::t_alu_sts i_alu_sts,
    output ipid_pkg::t_push         o_push,
    input  wire logic               i_res_ready
);
    import ipid_pkg::*;

    localparam int QUO_W = COEF_W + FRAC_BITS;
    localparam int C2_W  = QUO_W + 3;
    localparam logic [C2_W-1:0]   C2_ONE   = C2_W'(1) << FRAC_BITS;
    localparam logic [OPND_W-1:0] OPND_ONE = OPND_W'(1) << FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIV_R  = 11'b000_0000_0010,
        S_DIV_S  = 11'b000_0000_0100,
        S_COEF   = 11'b000_0000_1000,
        S_MUL_Q1 = 11'b000_0001_0000,
        S_MUL_Q3 = 11'b000_0010_0000,
        S_MUL_Q2 = 11'b000_0100_0000,
        S_TERM1  = 11'b000_1000_0000,
        S_TERM2  = 11'b001_0000_0000,
        S_TERM3  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state, w_next;
    logic               r_issued, n_issued;
    logic               r_clr;

    logic [31:0]        r_err, r_last, r_older, r_drive;
    logic [QUO_W-1:0]   r_r, r_s;
    logic [C2_W-1:0]    r_c2;
    logic [TERM_W-1:0]  r_q1, r_q2m, r_q3;
    logic [63:0]        r_sum;

    logic               w_accept, w_capture, w_op_state;
    logic [COEF_W-1:0]  w_t0, w_ti;
    logic [32:0]        w_diff;
    logic [31:0]        w_err_sat;
    logic [C2_W-1:0]    w_c2_mag;
    logic [31:0]        w_sel_e, w_abs_e;
    logic               w_term_neg;
    logic [63:0]        w_term;
    logic               w_fits;
    logic [31:0]        w_drive_new;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_capture  = r_issued && i_alu_sts.done;

    // A zero time constant counts as one LSB.
    assign w_t0 = (i_cfg.sample_step == '0) ? COEF_W'(1) : i_cfg.sample_step;
    assign w_ti = (i_cfg.integral_time == '0) ? COEF_W'(1) : i_cfg.integral_time;

    assign w_diff    = {i_cfg.target_value[31], i_cfg.target_value}
                     - {i_in_word.measured[31], i_in_word.measured};
    assign w_err_sat = (w_diff[32] != w_diff[31]) ? (w_diff[32] ? INT_MIN : INT_MAX)
                                                  : w_diff[31:0];

    assign w_c2_mag = r_c2[C2_W-1] ? (~r_c2 + C2_W'(1)) : r_c2;
    assign w_abs_e  = w_sel_e[31] ? (~w_sel_e + 32'd1) : w_sel_e;
    assign w_term   = 64'(i_alu_sts.prod);

    // Operand selection and schedule. Coefficient q2 is negative when c2 is
    // not, so its term sign flips against the error sign.
    always_comb begin
        w_op_state       = 1'b1;
        w_next           = S_IDLE;
        w_sel_e          = r_err;
        w_term_neg       = 1'b0;
        o_alu_cmd.op     = ALU_MUL;
        o_alu_cmd.opnd_a = '0;
        o_alu_cmd.opnd_b = '0;
        case (r_state)
            S_DIV_R: begin
                o_alu_cmd.op     = ALU_DIV;
                o_alu_cmd.opnd_a = OPND_W'(i_cfg.derivative_time) << FRAC_BITS;
                o_alu_cmd.opnd_b = MUL_STEPS'(w_t0);
                w_next           = S_DIV_S;
            end
            S_DIV_S: begin
                o_alu_cmd.op     = ALU_DIV;
                o_alu_cmd.opnd_a = OPND_W'(w_t0) << FRAC_BITS;
                o_alu_cmd.opnd_b = MUL_STEPS'(w_ti);
                w_next           = S_COEF;
            end
            S_MUL_Q1: begin
                o_alu_cmd.opnd_a = OPND_W'(r_r) + OPND_ONE;
                o_alu_cmd.opnd_b = MUL_STEPS'(i_cfg.gain);
                w_next           = S_MUL_Q3;
            end
            S_MUL_Q3: begin
                o_alu_cmd.opnd_a = OPND_W'(r_r);
                o_alu_cmd.opnd_b = MUL_STEPS'(i_cfg.gain);
                w_next           = S_MUL_Q2;
            end
            S_MUL_Q2: begin
                o_alu_cmd.opnd_a = OPND_W'(w_c2_mag);
                o_alu_cmd.opnd_b = MUL_STEPS'(i_cfg.gain);
                w_next           = S_TERM1;
            end
            S_TERM1: begin
                w_sel_e          = r_err;
                w_term_neg       = r_err[31];
                o_alu_cmd.opnd_a = OPND_W'(r_q1);
                o_alu_cmd.opnd_b = w_abs_e;
                w_next           = S_TERM2;
            end
            S_TERM2: begin
                w_sel_e          = r_last;
                w_term_neg       = !r_c2[C2_W-1] ^ r_last[31];
                o_alu_cmd.opnd_a = OPND_W'(r_q2m);
                o_alu_cmd.opnd_b = w_abs_e;
                w_next           = S_TERM3;
            end
            S_TERM3: begin
                w_sel_e          = r_older;
                w_term_neg       = r_older[31];
                o_alu_cmd.opnd_a = OPND_W'(r_q3);
                o_alu_cmd.opnd_b = w_abs_e;
                w_next           = S_DONE;
            end
            default: begin
                w_op_state = 1'b0;
            end
        endcase
        o_alu_cmd.start = w_op_state && !r_issued;
    end

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_word.cmd ? S_DONE : S_DIV_R;
                end
            end
            S_DIV_R, S_DIV_S, S_MUL_Q1, S_MUL_Q3, S_MUL_Q2,
            S_TERM1, S_TERM2, S_TERM3: begin
                if (!r_issued) begin
                    n_issued = 1'b1;
                end else if (i_alu_sts.done) begin
                    n_issued = 1'b0;
                    n_state  = w_next;
                end
            end
            S_COEF: begin
                n_state = S_MUL_Q1;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state  = S_IDLE;
                n_issued = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_clr    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            if (w_accept) begin
                r_clr <= i_in_word.cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= w_err_sat;
            r_sum <= {{32{r_drive[31]}}, r_drive};
        end
        if (r_state == S_COEF) begin
            r_c2 <= C2_ONE + (C2_W'(r_r) << 1) - C2_W'(r_s);
        end
        if (w_capture) begin
            case (r_state)
                S_DIV_R:  r_r   <= i_alu_sts.quo[QUO_W-1:0];
                S_DIV_S:  r_s   <= i_alu_sts.quo[QUO_W-1:0];
                S_MUL_Q1: r_q1  <= i_alu_sts.prod;
                S_MUL_Q3: r_q3  <= i_alu_sts.prod;
                S_MUL_Q2: r_q2m <= i_alu_sts.prod;
                S_TERM1, S_TERM2, S_TERM3: begin
                    r_sum <= w_term_neg ? (r_sum - w_term) : (r_sum + w_term);
                end
                default: begin
                end
            endcase
        end
    end

    // The sum fits 32 bits only when bits 63 down to 31 all agree.
    assign w_fits      = (&r_sum[63:31]) || !(|r_sum[63:31]);
    assign w_drive_new = w_fits ? r_sum[31:0] : (r_sum[63] ? INT_MIN : INT_MAX);

    always_comb begin
        o_push.valid = (r_state == S_DONE) && i_res_ready;
        if (r_clr) begin
            o_push.word = '0;
        end else begin
            o_push.word.error_now = r_err;
            o_push.word.drive     = w_drive_new;
            o_push.word.clipped   = !w_fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_older <= '0;
            r_drive <= '0;
        end else if (o_push.valid) begin
            if (r_clr) begin
                r_last  <= '0;
                r_older <= '0;
                r_drive <= '0;
            end else begin
                r_older <= r_last;
                r_last  <= r_err;
                r_drive <= w_drive_new;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/incremental_pid_controller.sv
// Top level of the incremental (velocity-form) PID controller: configuration
// registers, output word register, sequencer and shared arithmetic unit.
// Depends on ipid_pkg, ipid_alu and ipid_ctrl.
//
// Usage: configuration is written through i_cfg_we / i_cfg_index /
// i_cfg_data while the block is idle; unknown indexes are ignored. An input
// word is taken when i_in_valid is high and o_in_stall is low. A sample word
// (cmd 0) yields one output word holding the saturated error, the new drive
// value and the clip flag; a clear word (cmd 1) zeroes the error history and
// the drive and yields an all-zero word.
// For a sample (Q16.16 words when FRAC_BITS is 16), two restoring divisions
// and six shift-add multiplies run one after another on the single shared
// unit, and a new word can be taken in the cycle after the result is handed
// over. A clear word skips the arithmetic and goes straight to handing over
// its result. o_in_stall stays high while a word is being worked on.
// The result sits in an output register; while i_out_stall holds it, the
// block still takes and works the next word and only waits before writing
// its result. Reset (synchronous, active low) restores the default
// configuration and clears the history, the drive and all handshakes.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_controller #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ipid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ipid_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire ipid_pkg::t_in_word               i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output ipid_pkg::t_out_word                   o_out_word
);
    import ipid_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_alu_cmd  w_alu_cmd;
    t_alu_sts  w_alu_sts;
    t_push     w_push;
    logic      w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain            <= GAIN_RST;
            r_cfg.integral_time   <= TINT_RST;
            r_cfg.derivative_time <= TDER_RST;
            r_cfg.sample_step     <= TSTEP_RST;
            r_cfg.target_value    <= TARGET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN:            r_cfg.gain            <= i_cfg_data[COEF_W-1:0];
                REG_INTEGRAL_TIME:   r_cfg.integral_time   <= i_cfg_data[COEF_W-1:0];
                REG_DERIVATIVE_TIME: r_cfg.derivative_time <= i_cfg_data[COEF_W-1:0];
                REG_SAMPLE_STEP:     r_cfg.sample_step     <= i_cfg_data[COEF_W-1:0];
                REG_TARGET_VALUE:    r_cfg.target_value    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ipid_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_alu_cmd),
        .o_sts   (w_alu_sts)
    );

    ipid_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_alu_cmd   (w_alu_cmd),
        .i_alu_sts   (w_alu_sts),
        .o_push      (w_push),
        .i_res_ready (w_res_ready)
    );

    // The output slot takes a new word when empty or being drained.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out_word <= w_push.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input side not stalled after taking a word");

    a_push_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> w_res_ready)
        else $error("result written while the output word is held");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.clipped |->
            (o_out_word.drive == INT_MAX || o_out_word.drive == INT_MIN))
        else $error("clip flag set with drive away from the limits");
`endif

endmodule

`default_nettype wire

FILE: sim/incremental_pid_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_controller: directed and random sample
// and clear words under several register settings, checked against a predictor.
// Depends on ipid_pkg and the controller RTL.

localparam int FRAC = ipid_pkg::FRAC_BITS_DEF;
localparam longint ERR_MAX = 64'sd2147483647;
localparam longint ERR_MIN = -64'sd2147483648;
localparam logic [63:0] TERM_CAP = 64'(ipid_pkg::TERM_LIM);
localparam logic CMD_SAMPLE = 1'b0;
localparam logic CMD_CLEAR = 1'b1;

class pid_loop_model;
    logic [30:0] gain, int_time, der_time, step_time;
    logic signed [31:0] target;
    longint last_err, older_err, drive_acc;
    ipid_pkg::t_out_word pending_words[$];
    int mismatches, n_samples, n_clears, n_clipped, n_err_sat;

    function new();
        gain = ipid_pkg::GAIN_RST;
        int_time = ipid_pkg::TINT_RST;
        der_time = ipid_pkg::TDER_RST;
        step_time = ipid_pkg::TSTEP_RST;
        target = ipid_pkg::TARGET_RST;
        last_err = 0;
        older_err = 0;
        drive_acc = 0;
        mismatches = 0;
        n_samples = 0;
        n_clears = 0;
        n_clipped = 0;
        n_err_sat = 0;
    endfunction

    function void write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            ipid_pkg::REG_GAIN: gain = data[30:0];
            ipid_pkg::REG_INTEGRAL_TIME: int_time = data[30:0];
            ipid_pkg::REG_DERIVATIVE_TIME: der_time = data[30:0];
            ipid_pkg::REG_SAMPLE_STEP: step_time = data[30:0];
            ipid_pkg::REG_TARGET_VALUE: target = data;
            default: ;
        endcase
    endfunction

    // Product of two magnitudes scaled down by the fraction bits, capped at 2^60.
    static function logic [63:0] frac_mul_sat(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> FRAC;
        if (p > 128'(TERM_CAP))
            return TERM_CAP;
        return p[63:0];
    endfunction

    static function logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // The term truncates toward zero, so the sign is applied after the scaling.
    static function longint signed_term(longint q, longint e);
        logic [63:0] m;
        m = frac_mul_sat(magnitude(q), magnitude(e));
        return ((q < 0) != (e < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function void take_sample(ipid_pkg::t_in_word w);
        ipid_pkg::t_out_word res;
        longint err, c2, q1, q2, q3, sum;
        logic [63:0] t0, ti, one, r, s, q2m;
        res = '0;
        if (w.cmd == CMD_CLEAR) begin
            last_err = 0;
            older_err = 0;
            drive_acc = 0;
            n_clears++;
            pending_words.push_back(res);
            return;
        end
        err = longint'($signed(target)) - longint'($signed(w.measured));
        if (err > ERR_MAX) begin
            err = ERR_MAX;
            n_err_sat++;
        end else if (err < ERR_MIN) begin
            err = ERR_MIN;
            n_err_sat++;
        end
        // A zero time constant counts as one LSB.
        t0 = (step_time == '0) ? 64'd1 : 64'(step_time);
        ti = (int_time == '0) ? 64'd1 : 64'(int_time);
        one = 64'd1 << FRAC;
        r = (64'(der_time) << FRAC) / t0;
        s = (t0 << FRAC) / ti;
        q1 = longint'(frac_mul_sat(64'(gain), one + r));
        q3 = longint'(frac_mul_sat(64'(gain), r));
        c2 = longint'(one + (r << 1)) - longint'(s);
        q2m = frac_mul_sat(64'(gain), magnitude(c2));
        q2 = (c2 < 0) ? longint'(q2m) : -longint'(q2m);
        sum = drive_acc + signed_term(q1, err) + signed_term(q2, last_err)
            + signed_term(q3, older_err);
        if (sum > ERR_MAX) begin
            sum = ERR_MAX;
            res.clipped = 1'b1;
        end else if (sum < ERR_MIN) begin
            sum = ERR_MIN;
            res.clipped = 1'b1;
        end
        if (res.clipped)
            n_clipped++;
        drive_acc = sum;
        older_err = last_err;
        last_err = err;
        res.error_now = 32'(err);
        res.drive = 32'(sum);
        n_samples++;
        pending_words.push_back(res);
    endfunction

    task report_mismatch(string what);
        if (mismatches < 100)
            $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    task check_word(ipid_pkg::t_out_word got);
        ipid_pkg::t_out_word want;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("output word %h with nothing outstanding", got));
            return;
        end
        want = pending_words.pop_front();
        if (got.error_now !== want.error_now)
            report_mismatch($sformatf("error_now %h, expected %h", got.error_now,
                                      want.error_now));
        if (got.drive !== want.drive)
            report_mismatch($sformatf("drive %h, expected %h", got.drive, want.drive));
        if (got.clipped !== want.clipped)
            report_mismatch($sformatf("clipped %b, expected %b", got.clipped,
                                      want.clipped));
    endtask
endclass

module incremental_pid_controller_tb;
    import ipid_pkg::*;

    localparam int SAMPLE_LAT = 2 * FRAC + 272;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int WORDS_PER_PHASE = 116;
    localparam int HOLD_CYCLES = 1500;

    typedef enum {
        CFG_PLANT, CFG_NO_GAIN, CFG_NOISE, CFG_ZERO_TIME,
        CFG_FULL_SCALE, CFG_NO_DERIV, CFG_SAT_TARGET, CFG_WIDE
    } t_setting;

    localparam t_setting PHASE_PLAN [8] = '{CFG_PLANT, CFG_NO_GAIN, CFG_PLANT, CFG_NOISE,
                                            CFG_ZERO_TIME, CFG_FULL_SCALE, CFG_PLANT,
                                            CFG_NO_DERIV};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    t_in_word i_in_word = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out_word o_out_word;

    pid_loop_model model;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_left = 0;
    int n_holds = 0;
    int n_settings = 0;

    incremental_pid_controller #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word(o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver honors a requested long hold first, then stalls at random.
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_len != 0) begin
            hold_left = hold_len;
            hold_len = 0;
            n_holds++;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_word(o_out_word);
    end

    // All driving tasks start and end just after a falling edge.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        model.write_reg(idx, data);
    endtask

    task automatic configure(t_setting s);
        // Plant-like values first, then the setting's own overrides.
        write_cfg(REG_GAIN, $urandom_range(262144, 3277));
        write_cfg(REG_INTEGRAL_TIME, $urandom_range(6553600, 65536));
        write_cfg(REG_DERIVATIVE_TIME, $urandom_range(3276800));
        write_cfg(REG_SAMPLE_STEP, $urandom_range(655360, 6554));
        write_cfg(REG_TARGET_VALUE, $urandom_range(13107200) - 32'd6553600);
        case (s)
            CFG_NO_GAIN: write_cfg(REG_GAIN, '0);
            CFG_NO_DERIV: write_cfg(REG_DERIVATIVE_TIME, '0);
            CFG_ZERO_TIME: begin
                write_cfg(REG_SAMPLE_STEP, '0);
                // Only the dropped top bit is set, so the register reads zero.
                write_cfg(REG_INTEGRAL_TIME, 32'h8000_0000);
            end
            CFG_NOISE: begin
                for (int i = 0; i < (1 << CFG_IDX_W); i++)
                    write_cfg(CFG_IDX_W'(i), $urandom());
            end
            CFG_FULL_SCALE: begin
                write_cfg(REG_GAIN, 32'hffff_ffff);
                write_cfg(REG_INTEGRAL_TIME, 32'h7fff_ffff);
                write_cfg(REG_DERIVATIVE_TIME, 32'h7fff_ffff);
                write_cfg(REG_SAMPLE_STEP, 32'h7fff_ffff);
                write_cfg(REG_TARGET_VALUE, INT_MAX);
            end
            CFG_SAT_TARGET: begin
                write_cfg(REG_TARGET_VALUE, INT_MIN);
                write_cfg(REG_GAIN, 32'hffff_ffff);
                write_cfg(REG_DERIVATIVE_TIME, '0);
                write_cfg(REG_INTEGRAL_TIME, '0);
                write_cfg(REG_SAMPLE_STEP, '0);
            end
            CFG_WIDE: begin
                write_cfg(REG_TARGET_VALUE, INT_MAX);
                write_cfg(REG_DERIVATIVE_TIME, 32'h7fff_ffff);
                write_cfg(REG_SAMPLE_STEP, 32'd1);
                write_cfg(REG_INTEGRAL_TIME, 32'h7fff_ffff);
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        model.take_sample(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (model.pending_words.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly samples near the setpoint, as a running loop would see them.
    function automatic t_in_word make_word();
        t_in_word w;
        int pick;
        int offset;
        pick = $urandom_range(99);
        w.cmd = CMD_SAMPLE;
        w.measured = $urandom();
        if (pick < 5) begin
            w.cmd = CMD_CLEAR;
        end else if (pick < 80) begin
            offset = int'($urandom_range(1 << 19)) - (1 << 18);
            w.measured = model.target - offset;
        end else if (pick >= 95) begin
            case ($urandom_range(3))
                0: w.measured = INT_MIN;
                1: w.measured = INT_MAX;
                2: w.measured = '0;
                default: w.measured = '1;
            endcase
        end
        return w;
    endfunction

    initial begin
        model = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: clears from rest and back to back, zero error,
        // and errors beyond the 32-bit range.
        send_word('{CMD_CLEAR, 32'h1234_5678});
        send_word('{CMD_SAMPLE, TARGET_RST});
        send_word('{CMD_SAMPLE, 32'd0});
        send_word('{CMD_SAMPLE, 32'hffff_ffff});
        send_word('{CMD_SAMPLE, INT_MAX});
        repeat (3) send_word('{CMD_SAMPLE, INT_MIN});
        send_word('{CMD_CLEAR, INT_MAX});
        send_word('{CMD_CLEAR, INT_MIN});
        send_word('{CMD_SAMPLE, 32'd1});
        drain();

        // Lowest setpoint, top gain and zero time constants: negative error
        // overflow and a saturating drive.
        configure(CFG_SAT_TARGET);
        send_word('{CMD_SAMPLE, INT_MAX});
        send_word('{CMD_SAMPLE, INT_MAX});
        send_word('{CMD_SAMPLE, INT_MIN});
        send_word('{CMD_SAMPLE, 32'd0});
        send_word('{CMD_CLEAR, 32'd0});
        send_word('{CMD_SAMPLE, 32'd1});
        drain();

        configure(CFG_WIDE);
        send_word('{CMD_SAMPLE, INT_MIN});
        send_word('{CMD_SAMPLE, INT_MAX});
        send_word('{CMD_SAMPLE, 32'd0});
        send_word('{CMD_SAMPLE, 32'hffff_ffff});

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            configure(PHASE_PLAN[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
                1: begin sender_idle_pct = 45; recv_stall_pct = 0; end
                2: begin sender_idle_pct = 0; recv_stall_pct = 45; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // The output stays blocked long enough for the input to back up.
                if (k == 4 && (ph == 2 || ph == 5))
                    hold_len = HOLD_CYCLES;
                send_word(make_word());
            end
        end
        drain();
        repeat (2 * SAMPLE_LAT) @(negedge i_clk);

        $display("Ran %0d sample and %0d clear words over %0d register settings, %0d long holds.",
                 model.n_samples, model.n_clears, n_settings, n_holds);
        $display("Saw %0d clipped drive values and %0d saturated errors; %0d mismatches.",
                 model.n_clipped, model.n_err_sat, model.mismatches);
        if (model.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Timed out with %0d words outstanding.", model.pending_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
